>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted (active-low reset)
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Clocked assertion that is also checked during reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

>>> rtl/rv32a_pkg.sv
// ---------------------------------------------------------------------------
// rv32a_pkg
// Shared constants, types and the mnemonic table of the RV32I line assembler.
// ---------------------------------------------------------------------------
package rv32a_pkg;

    // Mnemonic buffer size in characters (6..8)
    localparam int MNEMONIC_CHARS = 6;
    localparam int TEXT_W         = MNEMONIC_CHARS * 8;
    localparam int CNT_W          = $clog2(MNEMONIC_CHARS + 1);

    // Longest table mnemonic is 5 characters
    localparam int TBL_CHARS = 5;
    localparam int TBL_W     = TBL_CHARS * 8;
    localparam int NUM_MNEM  = 37;
    localparam int NUM_OPS   = 3;

    // Characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Formats
    localparam logic [2:0] FMT_U    = 3'd0;
    localparam logic [2:0] FMT_J    = 3'd1;
    localparam logic [2:0] FMT_LOAD = 3'd2;
    localparam logic [2:0] FMT_S    = 3'd3;
    localparam logic [2:0] FMT_B    = 3'd4;
    localparam logic [2:0] FMT_I    = 3'd5;
    localparam logic [2:0] FMT_SH   = 3'd6;
    localparam logic [2:0] FMT_R    = 3'd7;

    // Major opcodes
    localparam logic [6:0] OPC_LUI    = 7'd55;
    localparam logic [6:0] OPC_AUIPC  = 7'd23;
    localparam logic [6:0] OPC_JAL    = 7'd111;
    localparam logic [6:0] OPC_JALR   = 7'd103;
    localparam logic [6:0] OPC_BRANCH = 7'd99;
    localparam logic [6:0] OPC_LOAD   = 7'd3;
    localparam logic [6:0] OPC_STORE  = 7'd35;
    localparam logic [6:0] OPC_OPIMM  = 7'd19;
    localparam logic [6:0] OPC_OP     = 7'd51;

    // funct7 values
    localparam logic [6:0] F7_BASE = 7'd0;
    localparam logic [6:0] F7_ALT  = 7'd32;

    // One table entry; text is right-justified, last character in the low byte
    typedef struct packed {
        logic [TBL_W-1:0] text;
        logic [2:0]       len;
        logic [2:0]       fmt;
        logic [6:0]       opc;
        logic [2:0]       f3;
        logic [6:0]       f7;
    } t_mnem;

    // A finished line handed from the parser to the encoder
    typedef struct packed {
        logic [TEXT_W-1:0]            text;
        logic [CNT_W-1:0]             cnt;
        logic [NUM_OPS-1:0][31:0]     vals;
        logic                         pend_vld;
        logic                         pend_neg;
        logic [1:0]                   pend_slot;
        logic [31:0]                  pend_mag;
    } t_line;

    localparam t_mnem MTABLE [NUM_MNEM] = '{
        '{"lui",   3'd3, FMT_U,    OPC_LUI,    3'd0, F7_BASE},
        '{"auipc", 3'd5, FMT_U,    OPC_AUIPC,  3'd0, F7_BASE},
        '{"jal",   3'd3, FMT_J,    OPC_JAL,    3'd0, F7_BASE},
        '{"jalr",  3'd4, FMT_LOAD, OPC_JALR,   3'd0, F7_BASE},
        '{"beq",   3'd3, FMT_B,    OPC_BRANCH, 3'd0, F7_BASE},
        '{"bne",   3'd3, FMT_B,    OPC_BRANCH, 3'd1, F7_BASE},
        '{"blt",   3'd3, FMT_B,    OPC_BRANCH, 3'd4, F7_BASE},
        '{"bge",   3'd3, FMT_B,    OPC_BRANCH, 3'd5, F7_BASE},
        '{"bltu",  3'd4, FMT_B,    OPC_BRANCH, 3'd6, F7_BASE},
        '{"bgeu",  3'd4, FMT_B,    OPC_BRANCH, 3'd7, F7_BASE},
        '{"lb",    3'd2, FMT_LOAD, OPC_LOAD,   3'd0, F7_BASE},
        '{"lh",    3'd2, FMT_LOAD, OPC_LOAD,   3'd1, F7_BASE},
        '{"lw",    3'd2, FMT_LOAD, OPC_LOAD,   3'd2, F7_BASE},
        '{"lbu",   3'd3, FMT_LOAD, OPC_LOAD,   3'd4, F7_BASE},
        '{"lhu",   3'd3, FMT_LOAD, OPC_LOAD,   3'd5, F7_BASE},
        '{"sb",    3'd2, FMT_S,    OPC_STORE,  3'd0, F7_BASE},
        '{"sh",    3'd2, FMT_S,    OPC_STORE,  3'd1, F7_BASE},
        '{"sw",    3'd2, FMT_S,    OPC_STORE,  3'd2, F7_BASE},
        '{"addi",  3'd4, FMT_I,    OPC_OPIMM,  3'd0, F7_BASE},
        '{"slti",  3'd4, FMT_I,    OPC_OPIMM,  3'd2, F7_BASE},
        '{"sltiu", 3'd5, FMT_I,    OPC_OPIMM,  3'd3, F7_BASE},
        '{"xori",  3'd4, FMT_I,    OPC_OPIMM,  3'd4, F7_BASE},
        '{"ori",   3'd3, FMT_I,    OPC_OPIMM,  3'd6, F7_BASE},
        '{"andi",  3'd4, FMT_I,    OPC_OPIMM,  3'd7, F7_BASE},
        '{"slli",  3'd4, FMT_SH,   OPC_OPIMM,  3'd1, F7_BASE},
        '{"srli",  3'd4, FMT_SH,   OPC_OPIMM,  3'd5, F7_BASE},
        '{"srai",  3'd4, FMT_SH,   OPC_OPIMM,  3'd5, F7_ALT},
        '{"add",   3'd3, FMT_R,    OPC_OP,     3'd0, F7_BASE},
        '{"sub",   3'd3, FMT_R,    OPC_OP,     3'd0, F7_ALT},
        '{"sll",   3'd3, FMT_R,    OPC_OP,     3'd1, F7_BASE},
        '{"slt",   3'd3, FMT_R,    OPC_OP,     3'd2, F7_BASE},
        '{"sltu",  3'd4, FMT_R,    OPC_OP,     3'd3, F7_BASE},
        '{"xor",   3'd3, FMT_R,    OPC_OP,     3'd4, F7_BASE},
        '{"srl",   3'd3, FMT_R,    OPC_OP,     3'd5, F7_BASE},
        '{"sra",   3'd3, FMT_R,    OPC_OP,     3'd5, F7_ALT},
        '{"or",    3'd2, FMT_R,    OPC_OP,     3'd6, F7_BASE},
        '{"and",   3'd3, FMT_R,    OPC_OP,     3'd7, F7_BASE}
    };

endpackage

>>> rtl/rv32a_parse.sv
// ---------------------------------------------------------------------------
// rv32a_parse
// Per-character parse state: mnemonic buffer, number accumulator and the
// operand slots. Presents the finished line on the last character's beat.
// ---------------------------------------------------------------------------
module rv32a_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_beat,
    input  logic [7:0]         i_char,
    input  logic               i_last,
    output rv32a_pkg::t_line   o_line
);

    localparam int TW = rv32a_pkg::TEXT_W;
    localparam int CW = rv32a_pkg::CNT_W;

    logic [TW-1:0]    r_text, n_text;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_in_ops, n_in_ops;
    logic [1:0]       r_slot, n_slot;
    logic [31:0]      r_accum, n_accum;
    logic             r_neg, n_neg;
    logic             r_in_num, n_in_num;
    logic [rv32a_pkg::NUM_OPS-1:0][31:0] r_vals, n_vals;

    logic             is_digit;
    logic [31:0]      accum_x10;
    logic [31:0]      signed_val;

    assign is_digit   = (i_char >= rv32a_pkg::CH_ZERO) && (i_char <= rv32a_pkg::CH_NINE);
    // accum * 10 + digit as shift-and-add
    assign accum_x10  = {r_accum[28:0], 3'b000} + {r_accum[30:0], 1'b0}
                      + {28'd0, i_char[3:0]};
    assign signed_val = r_neg ? (32'd0 - r_accum) : r_accum;

    // Next parse state for the current character
    always_comb begin
        n_text   = r_text;
        n_cnt    = r_cnt;
        n_in_ops = r_in_ops;
        n_slot   = r_slot;
        n_accum  = r_accum;
        n_neg    = r_neg;
        n_in_num = r_in_num;
        n_vals   = r_vals;
        if (!r_in_ops) begin
            if (i_char == rv32a_pkg::CH_SPACE) begin
                n_in_ops = 1'b1;
            end else if (r_cnt < CW'(rv32a_pkg::MNEMONIC_CHARS)) begin
                n_text = {r_text[TW-9:0], i_char};
                n_cnt  = r_cnt + 1'b1;
            end
        end else if (r_in_num) begin
            if (is_digit) begin
                n_accum = accum_x10;
            end else begin
                // non-digit closes the number and is otherwise dropped
                if (r_slot != 2'd3) begin
                    n_vals[r_slot] = signed_val;
                    n_slot         = r_slot + 2'd1;
                end
                n_in_num = 1'b0;
                n_neg    = 1'b0;
                n_accum  = 32'd0;
            end
        end else if (is_digit) begin
            n_in_num = 1'b1;
            n_neg    = 1'b0;
            n_accum  = {28'd0, i_char[3:0]};
        end else if (i_char == rv32a_pkg::CH_MINUS) begin
            n_in_num = 1'b1;
            n_neg    = 1'b1;
            n_accum  = 32'd0;
        end
    end

    // Finished line; an open number is left pending for the encoder to sign
    always_comb begin
        o_line.text      = n_text;
        o_line.cnt       = n_cnt;
        o_line.vals      = n_vals;
        o_line.pend_vld  = n_in_num && (n_slot != 2'd3);
        o_line.pend_neg  = n_neg;
        o_line.pend_slot = n_slot;
        o_line.pend_mag  = n_accum;
    end

    // Parse state registers, cleared after the last character of a line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_beat && i_last)) begin
            r_text   <= '0;
            r_cnt    <= '0;
            r_in_ops <= 1'b0;
            r_slot   <= 2'd0;
            r_accum  <= 32'd0;
            r_neg    <= 1'b0;
            r_in_num <= 1'b0;
            r_vals   <= '0;
        end else if (i_beat) begin
            r_text   <= n_text;
            r_cnt    <= n_cnt;
            r_in_ops <= n_in_ops;
            r_slot   <= n_slot;
            r_accum  <= n_accum;
            r_neg    <= n_neg;
            r_in_num <= n_in_num;
            r_vals   <= n_vals;
        end
    end

endmodule

>>> rtl/rv32a_encode.sv
// ---------------------------------------------------------------------------
// rv32a_encode
// Mnemonic lookup and R/I/S/B/U/J field packing for one finished line.
// ---------------------------------------------------------------------------
module rv32a_encode (
    input  rv32a_pkg::t_line   i_line,
    output logic [31:0]        o_word,
    output logic               o_known
);

    localparam int CW = rv32a_pkg::CNT_W;
    localparam int BW = rv32a_pkg::TBL_W;

    logic                                hit;
    rv32a_pkg::t_mnem                    sel;
    logic [rv32a_pkg::NUM_OPS-1:0][31:0] v;
    logic [31:0]                         pend_val;

    // Table match; entries are unique so the selected fields can be OR-ed
    always_comb begin
        hit = 1'b0;
        sel = '0;
        for (int i = 0; i < rv32a_pkg::NUM_MNEM; i++) begin
            if ((i_line.text[BW-1:0] == rv32a_pkg::MTABLE[i].text) &&
                (i_line.cnt == CW'(rv32a_pkg::MTABLE[i].len))) begin
                hit = 1'b1;
                sel = rv32a_pkg::t_mnem'(sel | rv32a_pkg::MTABLE[i]);
            end
        end
    end

    // Close the number still open at the end of the line
    assign pend_val = i_line.pend_neg ? (32'd0 - i_line.pend_mag) : i_line.pend_mag;

    always_comb begin
        v = i_line.vals;
        if (i_line.pend_vld) begin
            v[i_line.pend_slot] = pend_val;
        end
    end

    // Field packing per format
    always_comb begin
        case (sel.fmt)
            rv32a_pkg::FMT_U:
                o_word = {v[1][19:0], v[0][4:0], sel.opc};
            rv32a_pkg::FMT_J:
                o_word = {v[1][20], v[1][10:1], v[1][11], v[1][19:12], v[0][4:0], sel.opc};
            rv32a_pkg::FMT_LOAD:
                o_word = {v[1][11:0], v[2][4:0], sel.f3, v[0][4:0], sel.opc};
            rv32a_pkg::FMT_S:
                o_word = {v[1][11:5], v[0][4:0], v[2][4:0], sel.f3, v[1][4:0], sel.opc};
            rv32a_pkg::FMT_B:
                o_word = {v[2][12], v[2][10:5], v[1][4:0], v[0][4:0], sel.f3,
                          v[2][4:1], v[2][11], sel.opc};
            rv32a_pkg::FMT_I:
                o_word = {v[2][11:0], v[1][4:0], sel.f3, v[0][4:0], sel.opc};
            default:
                // shifts and register ALU share the R layout
                o_word = {sel.f7, v[2][4:0], v[1][4:0], sel.f3, v[0][4:0], sel.opc};
        endcase
        if (!hit) begin
            o_word = 32'd0;
        end
    end

    assign o_known = hit;

endmodule

>>> rtl/rv32i_text_assembler_top.sv
// ---------------------------------------------------------------------------
// rv32i_text_assembler_top
// Line assembler: ASCII characters in, one RV32I instruction word per line.
// ---------------------------------------------------------------------------
// Input channel: one character per beat (i_char_in, i_line_end) with
// i_in_valid / o_in_ready. Output channel: one beat per line carrying
// o_instr_word and o_known_mnemonic with o_out_valid / i_out_ready.
// Beats without i_line_end only update the parse state and give no result.
// Throughput: one character per cycle while o_in_ready is high. The beat that
// carries i_line_end is captured in a line register; the lookup and packing
// run from there into the output register, which offers the result.
// The line register and the output register form a two-deep stage: while
// the receiver stalls, characters of the next line keep flowing until a
// second finished line waits in the line register, then o_in_ready drops
// until the output beat is taken.
// Reset (i_rst_n low, synchronous) clears the parse state and both valid
// flags; no result is pending afterwards.
// ---------------------------------------------------------------------------
module rv32i_text_assembler_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_char_in,
    input  logic        i_line_end,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    output logic [31:0] o_instr_word,
    output logic        o_known_mnemonic,
    output logic        o_out_valid,
    input  logic        i_out_ready
);

    logic              in_beat;
    logic              ln_go;
    rv32a_pkg::t_line  line_next;
    rv32a_pkg::t_line  r_line;
    logic              r_ln_vld;
    logic [31:0]       enc_word;
    logic              enc_known;
    logic [31:0]       r_word;
    logic              r_known;
    logic              r_out_vld;

    // Handshake: line stage moves when the output register is free or drains
    assign ln_go      = !r_out_vld || i_out_ready;
    assign o_in_ready = !r_ln_vld || ln_go;
    assign in_beat    = i_in_valid && o_in_ready;

    rv32a_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (in_beat),
        .i_char  (i_char_in),
        .i_last  (i_line_end),
        .o_line  (line_next)
    );

    // Line register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ln_vld <= 1'b0;
        end else if (in_beat && i_line_end) begin
            r_ln_vld <= 1'b1;
        end else if (ln_go) begin
            r_ln_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat && i_line_end) begin
            r_line <= line_next;
        end
    end

    rv32a_encode u_encode (
        .i_line  (r_line),
        .o_word  (enc_word),
        .o_known (enc_known)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_ln_vld && ln_go) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ln_vld && ln_go) begin
            r_word  <= enc_word;
            r_known <= enc_known;
        end
    end

    assign o_instr_word     = r_word;
    assign o_known_mnemonic = r_known;
    assign o_out_valid      = r_out_vld;

endmodule

>>> rtl/rv32a_checker.sv
// ---------------------------------------------------------------------------
// rv32a_checker
// Port-level assertions for the line assembler, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rv32a_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_line_end,
    input  logic        i_in_valid,
    input  logic        o_in_ready,
    input  logic [31:0] o_instr_word,
    input  logic        o_known_mnemonic,
    input  logic        o_out_valid,
    input  logic        i_out_ready
);

    logic out_stall;
    logic unknown_beat;
    logic in_last_beat;

    assign out_stall    = o_out_valid && !i_out_ready;
    assign unknown_beat = o_out_valid && !o_known_mnemonic;
    assign in_last_beat = i_in_valid && o_in_ready && i_line_end;

    // A stalled result beat stays offered and unchanged
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, out_stall |=> o_out_valid)
    `ASSERT_CLK(a_out_stable, i_clk, i_rst_n, out_stall |=> $stable(o_instr_word))

    // Unknown mnemonic always encodes as zero
    `ASSERT_CLK(a_unknown_zero, i_clk, i_rst_n, unknown_beat |-> o_instr_word == 32'd0)

    // A new result follows an accepted line-end beat
    `ASSERT_CLK(a_rise_from_line, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(in_last_beat, 2))

    // Reset leaves no result pending
    `ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind rv32i_text_assembler_top rv32a_checker u_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_line_end       (i_line_end),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_instr_word     (o_instr_word),
    .o_known_mnemonic (o_known_mnemonic),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready)
);
